// File: design/psa_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and sizes for the purgeable segment allocator.
// No dependencies; imported by every module of the block.
package psa_pkg;

	localparam int NUM_DESC   = 32;
	localparam int ADDR_W     = $clog2(NUM_DESC);
	localparam int IDX_W      = 6;
	localparam int STEP_W     = $clog2(NUM_DESC + 2);
	localparam int HANDLE_W   = 8;
	localparam int NEED_W     = 17;
	localparam int NOTICE_W   = 6;

	localparam logic [IDX_W-1:0]    NIL         = 6'd63;
	localparam logic [NOTICE_W-1:0] MAX_NOTICES = 6'd63;
	localparam logic [15:0]         TOP_PARA    = 16'hffff;

	localparam logic [15:0] RST_NEAR_START = 16'd4096;
	localparam logic [15:0] RST_NEAR_PARAS = 16'd213;
	localparam logic [15:0] RST_FAR_START  = 16'd4309;
	localparam logic [15:0] RST_FAR_PARAS  = 16'd28037;

	typedef enum logic [2:0] {
		OP_INIT    = 3'd0,
		OP_ALLOC   = 3'd1,
		OP_FREE    = 3'd2,
		OP_PURGE   = 3'd3,
		OP_LOCK    = 3'd4,
		OP_COMPACT = 3'd5
	} psa_op_t;

	typedef enum logic [1:0] {
		KIND_STATUS = 2'd0,
		KIND_PURGED = 2'd1,
		KIND_MOVED  = 2'd2
	} psa_kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOMEM    = 2'd1,
		ST_NODESC   = 2'd2,
		ST_NOTFOUND = 2'd3
	} psa_status_t;

	typedef enum logic [1:0] {
		CFG_NEAR_START = 2'd0,
		CFG_NEAR_PARAS = 2'd1,
		CFG_FAR_START  = 2'd2,
		CFG_FAR_PARAS  = 2'd3
	} psa_cfg_idx_t;

	// controller -> datapath: one read and one masked write per cycle
	typedef struct packed {
		logic [ADDR_W-1:0]   raddr;
		logic [ADDR_W-1:0]   waddr;
		logic                we_start;
		logic                we_len;
		logic                we_lock;
		logic                we_purge;
		logic                we_owner;
		logic                we_link;
		logic [15:0]         wstart;
		logic [15:0]         wlen;
		logic                wlock;
		logic [1:0]          wpurge;
		logic [HANDLE_W-1:0] wowner;
		logic [IDX_W-1:0]    wlink;
	} psa_cmd_t;

	// datapath -> controller: registered read data and heap settings
	typedef struct packed {
		logic [15:0]         start;
		logic [15:0]         len;
		logic                lock;
		logic [1:0]          purge;
		logic [HANDLE_W-1:0] owner;
		logic [IDX_W-1:0]    link;
		logic [15:0]         rend;
		logic [15:0]         near_start;
		logic [15:0]         near_paras;
		logic [15:0]         far_start;
		logic [15:0]         far_paras;
	} psa_stat_t;

	typedef struct packed {
		logic                strobe;
		logic [1:0]          kind;
		logic [HANDLE_W-1:0] owner;
		logic [15:0]         new_seg;
		logic [15:0]         old_seg;
		logic [15:0]         move_len;
		logic [1:0]          status;
		logic [15:0]         unused;
		logic [15:0]         reclaim;
		logic                last;
	} psa_result_t;

	function automatic logic [IDX_W-1:0] nxt_f(input logic [IDX_W-1:0] lnk);
		return (lnk < IDX_W'(NUM_DESC)) ? lnk : NIL;
	endfunction

endpackage

// File: design/psa_datapath.sv
`timescale 1ns / 1ps
// Descriptor store (one read, one masked write per cycle, registered read)
// and the heap setting registers. Depends on psa_pkg.
module psa_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  psa_pkg::psa_cmd_t     cmd,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_idx,
	input  logic [15:0]           cfg_wdata,
	output psa_pkg::psa_stat_t    stat
);
	import psa_pkg::*;

	logic [15:0]         mem_start [NUM_DESC];
	logic [15:0]         mem_len   [NUM_DESC];
	logic                mem_lock  [NUM_DESC];
	logic [1:0]          mem_purge [NUM_DESC];
	logic [HANDLE_W-1:0] mem_owner [NUM_DESC];
	logic [IDX_W-1:0]    mem_link  [NUM_DESC];

	logic [15:0]         rd_start_q;
	logic [15:0]         rd_len_q;
	logic                rd_lock_q;
	logic [1:0]          rd_purge_q;
	logic [HANDLE_W-1:0] rd_owner_q;
	logic [IDX_W-1:0]    rd_link_q;

	logic [15:0] near_start_q, near_paras_q, far_start_q, far_paras_q;

	always_ff @(posedge clk) begin
		if (cmd.we_start) mem_start[cmd.waddr] <= cmd.wstart;
		if (cmd.we_len)   mem_len[cmd.waddr]   <= cmd.wlen;
		if (cmd.we_lock)  mem_lock[cmd.waddr]  <= cmd.wlock;
		if (cmd.we_purge) mem_purge[cmd.waddr] <= cmd.wpurge;
		if (cmd.we_owner) mem_owner[cmd.waddr] <= cmd.wowner;
		if (cmd.we_link)  mem_link[cmd.waddr]  <= cmd.wlink;
		rd_start_q <= mem_start[cmd.raddr];
		rd_len_q   <= mem_len[cmd.raddr];
		rd_lock_q  <= mem_lock[cmd.raddr];
		rd_purge_q <= mem_purge[cmd.raddr];
		rd_owner_q <= mem_owner[cmd.raddr];
		rd_link_q  <= mem_link[cmd.raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_start_q <= RST_NEAR_START;
			near_paras_q <= RST_NEAR_PARAS;
			far_start_q  <= RST_FAR_START;
			far_paras_q  <= RST_FAR_PARAS;
		end else if (cfg_we) begin
			case (psa_cfg_idx_t'(cfg_idx))
				CFG_NEAR_START: near_start_q <= cfg_wdata;
				CFG_NEAR_PARAS: near_paras_q <= cfg_wdata;
				CFG_FAR_START:  far_start_q  <= cfg_wdata;
				CFG_FAR_PARAS:  far_paras_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		stat.start      = rd_start_q;
		stat.len        = rd_len_q;
		stat.lock       = rd_lock_q;
		stat.purge      = rd_purge_q;
		stat.owner      = rd_owner_q;
		stat.link       = rd_link_q;
		stat.rend       = rd_start_q + rd_len_q;
		stat.near_start = near_start_q;
		stat.near_paras = near_paras_q;
		stat.far_start  = far_start_q;
		stat.far_paras  = far_paras_q;
	end

endmodule

// File: design/psa_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for init, allocate, free, purge/lock update, compaction and
// the closing totals walk; drives the descriptor store. Depends on psa_pkg.
module psa_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [2:0]                    opcode,
	input  logic [psa_pkg::HANDLE_W-1:0]  handle,
	input  logic [19:0]                   size_bytes,
	input  logic [1:0]                    purge_level,
	input  logic                          lock_flag,
	output logic                          busy,
	output psa_pkg::psa_cmd_t             cmd,
	input  psa_pkg::psa_stat_t            stat,
	output psa_pkg::psa_result_t          res
);
	import psa_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE, S_DISPATCH, S_INIT_W,
		S_TOT_INIT, S_TOT_RD, S_TOT_A, S_TOT_RD2, S_TOT_C,
		S_CMP_INIT, S_CMP_CHK, S_CMP_A, S_CMP_B,
		S_AL_RDND, S_AL_SPARE, S_AL_PASS, S_AL_RDLAST, S_AL_LAST, S_AL_CHK,
		S_AL_EVAL, S_AL_LINK, S_AL_ND, S_AL_PCHK, S_AL_PREL, S_AL_FAIL,
		S_FR_RDROV, S_FR_ROV, S_FR_RDHEAD, S_FR_HEAD, S_FR_CHK, S_FR_EVAL,
		S_FR_UNLINK, S_FR_REL,
		S_FD_RD, S_FD_EVAL
	} state_t;

	state_t                state_q;
	psa_op_t               op_q;
	logic [HANDLE_W-1:0]   h_q;
	logic [NEED_W-1:0]     needed_q;
	logic [1:0]            pl_q;
	logic                  lk_q;
	logic [1:0]            st_q;
	logic [HANDLE_W-1:0]   own_q;
	logic [15:0]           seg_q;
	logic                  started_q;
	logic [IDX_W-1:0]      spare_q, rover_q;
	logic [IDX_W-1:0]      scan_q, last_q, nx_q, nd_q, purge_q, plink_q;
	logic [IDX_W-1:0]      lastscan_q, endscan_q, cur_q, fstart_q;
	logic [STEP_W-1:0]     steps_q;
	logic [1:0]            pass_q;
	logic                  cmp_alloc_q;
	logic [15:0]           start_q, startseg_q, end_q, un_q, rc_q;
	logic [NOTICE_W-1:0]   ncnt_q;
	psa_result_t           res_q;

	logic [20:0]           need_sum;
	logic [IDX_W-1:0]      rd_nxt;
	logic [15:0]           gap;
	logic                  fits;
	logic                  skip_blk;
	logic [15:0]           endfree1, endfree2;

	function automatic logic owned(input logic [IDX_W-1:0] i,
		input logic [HANDLE_W-1:0] own, input logic [HANDLE_W-1:0] h);
		return (i >= IDX_W'(3)) && (i < IDX_W'(NUM_DESC)) && (own == h);
	endfunction

	assign need_sum = {1'b0, size_bytes} + 21'd15;
	assign rd_nxt   = nxt_f(stat.link);
	assign gap      = stat.start - startseg_q;
	assign fits     = ({1'b0, gap} >= needed_q);
	assign skip_blk = !stat.lock && (stat.purge != 2'd0);
	assign endfree1 = stat.near_start + stat.near_paras;
	assign endfree2 = stat.far_start + stat.far_paras;
	assign busy     = (state_q != S_IDLE);
	assign res      = res_q;

	always_comb begin
		cmd = '0;
		cmd.raddr = scan_q[ADDR_W-1:0];
		cmd.waddr = scan_q[ADDR_W-1:0];
		case (state_q)
			S_INIT_W: begin
				cmd.waddr    = cur_q[ADDR_W-1:0];
				cmd.we_start = 1'b1;
				cmd.we_len   = 1'b1;
				cmd.we_lock  = 1'b1;
				cmd.we_purge = 1'b1;
				cmd.we_owner = 1'b1;
				cmd.we_link  = 1'b1;
				cmd.wlock    = (cur_q < IDX_W'(3));
				cmd.wlink    = (cur_q == IDX_W'(NUM_DESC - 1)) ? NIL : cur_q + IDX_W'(1);
				if (cur_q == IDX_W'(0)) begin
					cmd.wlen = stat.near_start;
				end else if (cur_q == IDX_W'(1)) begin
					cmd.wstart = endfree1;
					cmd.wlen   = stat.far_start - endfree1;
				end else if (cur_q == IDX_W'(2)) begin
					cmd.wstart = endfree2;
					cmd.wlen   = TOP_PARA - endfree2;
					cmd.wlink  = NIL;
				end
			end
			S_CMP_A: begin
				if (!stat.lock && stat.purge != 2'd0) begin
					cmd.we_link = 1'b1;
					cmd.wlink   = spare_q;
				end else if (!stat.lock && stat.start != start_q) begin
					cmd.we_start = 1'b1;
					cmd.wstart   = start_q;
				end
			end
			S_CMP_B: begin
				cmd.waddr   = last_q[ADDR_W-1:0];
				cmd.we_link = 1'b1;
				cmd.wlink   = nx_q;
			end
			S_AL_RDND:   cmd.raddr = nd_q[ADDR_W-1:0];
			S_AL_RDLAST: cmd.raddr = lastscan_q[ADDR_W-1:0];
			S_AL_LINK: begin
				cmd.waddr   = lastscan_q[ADDR_W-1:0];
				cmd.we_link = 1'b1;
				cmd.wlink   = nd_q;
			end
			S_AL_ND: begin
				cmd.waddr    = nd_q[ADDR_W-1:0];
				cmd.we_start = 1'b1;
				cmd.we_len   = 1'b1;
				cmd.we_lock  = 1'b1;
				cmd.we_purge = 1'b1;
				cmd.we_owner = 1'b1;
				cmd.we_link  = 1'b1;
				cmd.wstart   = startseg_q;
				cmd.wlen     = needed_q[15:0];
				cmd.wowner   = h_q;
				cmd.wlink    = scan_q;
			end
			S_AL_PCHK: cmd.raddr = purge_q[ADDR_W-1:0];
			S_AL_PREL: begin
				cmd.waddr   = purge_q[ADDR_W-1:0];
				cmd.we_link = 1'b1;
				cmd.wlink   = spare_q;
			end
			S_AL_FAIL: begin
				cmd.waddr   = nd_q[ADDR_W-1:0];
				cmd.we_link = 1'b1;
				cmd.wlink   = spare_q;
			end
			S_FR_RDROV:  cmd.raddr = rover_q[ADDR_W-1:0];
			S_FR_RDHEAD: cmd.raddr = '0;
			S_FR_UNLINK: begin
				cmd.waddr   = last_q[ADDR_W-1:0];
				cmd.we_link = 1'b1;
				cmd.wlink   = nx_q;
			end
			S_FR_REL: begin
				cmd.we_link = 1'b1;
				cmd.wlink   = spare_q;
			end
			S_FD_RD: cmd.raddr = cur_q[ADDR_W-1:0];
			S_FD_EVAL: begin
				cmd.waddr = cur_q[ADDR_W-1:0];
				if (owned(cur_q, stat.owner, h_q)) begin
					cmd.we_purge = (op_q == OP_PURGE);
					cmd.we_lock  = (op_q == OP_LOCK);
				end
				cmd.wpurge = pl_q;
				cmd.wlock  = lk_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			started_q   <= 1'b0;
			spare_q     <= '0;
			rover_q     <= '0;
			res_q       <= '0;
			ncnt_q      <= '0;
			cmp_alloc_q <= 1'b0;
		end else begin
			res_q.strobe <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q     <= psa_op_t'(opcode);
						h_q      <= handle;
						needed_q <= need_sum[20:4];
						pl_q     <= purge_level;
						lk_q     <= lock_flag;
						st_q     <= ST_OK;
						own_q    <= '0;
						seg_q    <= '0;
						ncnt_q   <= '0;
						state_q  <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					cur_q    <= rover_q;
					fstart_q <= rover_q;
					steps_q  <= '0;
					if (op_q == OP_INIT) begin
						cur_q   <= '0;
						state_q <= S_INIT_W;
					end else if (!started_q && op_q <= OP_COMPACT) begin
						st_q    <= ST_NOTFOUND;
						state_q <= S_TOT_INIT;
					end else begin
						case (op_q)
							OP_ALLOC: begin
								if (spare_q >= IDX_W'(NUM_DESC)) begin
									st_q    <= ST_NODESC;
									state_q <= S_TOT_INIT;
								end else begin
									nd_q    <= spare_q;
									state_q <= S_AL_RDND;
								end
							end
							OP_FREE:  state_q <= S_FR_RDROV;
							OP_PURGE: state_q <= S_FD_RD;
							OP_LOCK:  state_q <= S_FD_RD;
							OP_COMPACT: begin
								cmp_alloc_q <= 1'b0;
								state_q     <= S_CMP_INIT;
							end
							default: state_q <= S_TOT_INIT;
						endcase
					end
				end
				S_INIT_W: begin
					if (cur_q == IDX_W'(NUM_DESC - 1)) begin
						spare_q   <= IDX_W'(3);
						rover_q   <= '0;
						started_q <= 1'b1;
						state_q   <= S_TOT_INIT;
					end else begin
						cur_q <= cur_q + IDX_W'(1);
					end
				end

				// closing totals walk
				S_TOT_INIT: begin
					scan_q  <= '0;
					un_q    <= '0;
					rc_q    <= '0;
					steps_q <= '0;
					if (!started_q) begin
						res_q   <= '{strobe: 1'b1, kind: KIND_STATUS, owner: own_q,
							new_seg: seg_q, old_seg: 16'd0, move_len: 16'd0, status: st_q,
							unused: 16'd0, reclaim: 16'd0, last: 1'b1};
						state_q <= S_IDLE;
					end else begin
						state_q <= S_TOT_RD;
					end
				end
				S_TOT_RD: state_q <= S_TOT_A;
				S_TOT_A: begin
					if (rd_nxt == NIL || steps_q > STEP_W'(NUM_DESC)) begin
						res_q   <= '{strobe: 1'b1, kind: KIND_STATUS, owner: own_q,
							new_seg: seg_q, old_seg: 16'd0, move_len: 16'd0, status: st_q,
							unused: un_q, reclaim: rc_q, last: 1'b1};
						state_q <= S_IDLE;
					end else begin
						steps_q <= steps_q + STEP_W'(1);
						if (skip_blk) rc_q <= rc_q + stat.len;
						end_q   <= stat.rend;
						scan_q  <= rd_nxt;
						state_q <= S_TOT_RD2;
					end
				end
				S_TOT_RD2: state_q <= S_TOT_C;
				S_TOT_C: begin
					// read address stays on scan, so the next state sees this entry again
					un_q    <= un_q + (stat.start - end_q);
					rc_q    <= rc_q + (stat.start - end_q);
					state_q <= S_TOT_A;
				end

				// compaction
				S_CMP_INIT: begin
					scan_q  <= '0;
					last_q  <= '0;
					start_q <= '0;
					steps_q <= '0;
					state_q <= S_CMP_CHK;
				end
				S_CMP_CHK: begin
					if (scan_q == NIL || steps_q > STEP_W'(NUM_DESC)) begin
						rover_q <= '0;
						if (cmp_alloc_q) begin
							lastscan_q <= '0;
							endscan_q  <= NIL;
							state_q    <= S_AL_RDLAST;
						end else begin
							state_q <= S_TOT_INIT;
						end
					end else begin
						steps_q <= steps_q + STEP_W'(1);
						state_q <= S_CMP_A;
					end
				end
				S_CMP_A: begin
					scan_q  <= rd_nxt;
					state_q <= S_CMP_CHK;
					if (stat.lock) begin
						start_q <= stat.rend;
						last_q  <= scan_q;
					end else if (stat.purge != 2'd0) begin
						if (ncnt_q < MAX_NOTICES) begin
							res_q  <= '{strobe: 1'b1, kind: KIND_PURGED, owner: stat.owner,
								default: '0};
							ncnt_q <= ncnt_q + NOTICE_W'(1);
						end
						spare_q <= scan_q;
						nx_q    <= rd_nxt;
						state_q <= S_CMP_B;
					end else begin
						if (stat.start != start_q) begin
							if (ncnt_q < MAX_NOTICES) begin
								res_q  <= '{strobe: 1'b1, kind: KIND_MOVED, owner: stat.owner,
									new_seg: start_q, old_seg: stat.start, move_len: stat.len,
									default: '0};
								ncnt_q <= ncnt_q + NOTICE_W'(1);
							end
							start_q <= start_q + stat.len;
						end else begin
							start_q <= stat.rend;
						end
						last_q <= scan_q;
					end
				end
				S_CMP_B: state_q <= S_CMP_CHK;

				// allocation
				S_AL_RDND: state_q <= S_AL_SPARE;
				S_AL_SPARE: begin
					spare_q <= rd_nxt;
					pass_q  <= 2'd0;
					state_q <= S_AL_PASS;
				end
				S_AL_PASS: begin
					case (pass_q)
						2'd0: begin
							lastscan_q <= rover_q;
							endscan_q  <= NIL;
							state_q    <= S_AL_RDLAST;
						end
						2'd1: begin
							if (rover_q == '0) begin
								pass_q <= 2'd2;
							end else begin
								lastscan_q <= '0;
								endscan_q  <= rover_q;
								state_q    <= S_AL_RDLAST;
							end
						end
						2'd2: begin
							cmp_alloc_q <= 1'b1;
							state_q     <= S_CMP_INIT;
						end
						default: state_q <= S_AL_FAIL;
					endcase
				end
				S_AL_RDLAST: state_q <= S_AL_LAST;
				S_AL_LAST: begin
					startseg_q <= stat.rend;
					scan_q     <= rd_nxt;
					plink_q    <= rd_nxt;
					steps_q    <= '0;
					state_q    <= S_AL_CHK;
				end
				S_AL_CHK: begin
					if (scan_q == endscan_q || scan_q == NIL || steps_q > STEP_W'(NUM_DESC)) begin
						pass_q  <= pass_q + 2'd1;
						state_q <= S_AL_PASS;
					end else begin
						steps_q <= steps_q + STEP_W'(1);
						state_q <= S_AL_EVAL;
					end
				end
				S_AL_EVAL: begin
					if (fits) begin
						state_q <= S_AL_LINK;
					end else begin
						// purgeable unlocked blocks stay inside the gap being measured
						if (!skip_blk) begin
							lastscan_q <= scan_q;
							startseg_q <= stat.rend;
							plink_q    <= rd_nxt;
						end
						scan_q  <= rd_nxt;
						state_q <= S_AL_CHK;
					end
				end
				S_AL_LINK: begin
					purge_q <= plink_q;
					state_q <= S_AL_ND;
				end
				S_AL_ND: begin
					steps_q <= '0;
					state_q <= S_AL_PCHK;
				end
				S_AL_PCHK: begin
					if (purge_q == scan_q || purge_q == NIL || steps_q > STEP_W'(NUM_DESC)) begin
						rover_q <= nd_q;
						seg_q   <= startseg_q;
						own_q   <= h_q;
						st_q    <= ST_OK;
						state_q <= S_TOT_INIT;
					end else begin
						steps_q <= steps_q + STEP_W'(1);
						state_q <= S_AL_PREL;
					end
				end
				S_AL_PREL: begin
					if (ncnt_q < MAX_NOTICES) begin
						res_q  <= '{strobe: 1'b1, kind: KIND_PURGED, owner: stat.owner,
							default: '0};
						ncnt_q <= ncnt_q + NOTICE_W'(1);
					end
					spare_q <= purge_q;
					purge_q <= rd_nxt;
					state_q <= S_AL_PCHK;
				end
				S_AL_FAIL: begin
					spare_q <= nd_q;
					st_q    <= ST_NOMEM;
					state_q <= S_TOT_INIT;
				end

				// free
				S_FR_RDROV: state_q <= S_FR_ROV;
				S_FR_ROV: begin
					if (owned(rover_q, stat.owner, h_q)) rover_q <= '0;
					last_q  <= '0;
					state_q <= S_FR_RDHEAD;
				end
				S_FR_RDHEAD: state_q <= S_FR_HEAD;
				S_FR_HEAD: begin
					scan_q  <= rd_nxt;
					steps_q <= '0;
					state_q <= S_FR_CHK;
				end
				S_FR_CHK: begin
					if (scan_q == NIL) begin
						st_q    <= ST_NOTFOUND;
						state_q <= S_TOT_INIT;
					end else begin
						state_q <= S_FR_EVAL;
					end
				end
				S_FR_EVAL: begin
					if (owned(scan_q, stat.owner, h_q)) begin
						nx_q    <= rd_nxt;
						state_q <= S_FR_UNLINK;
					end else if (steps_q <= STEP_W'(NUM_DESC)) begin
						steps_q <= steps_q + STEP_W'(1);
						last_q  <= scan_q;
						scan_q  <= rd_nxt;
						state_q <= S_FR_CHK;
					end else begin
						st_q    <= ST_NOTFOUND;
						state_q <= S_TOT_INIT;
					end
				end
				S_FR_UNLINK: state_q <= S_FR_REL;
				S_FR_REL: begin
					spare_q <= scan_q;
					state_q <= S_TOT_INIT;
				end

				// handle search from the rover, wrapping at the list end
				S_FD_RD: state_q <= S_FD_EVAL;
				S_FD_EVAL: begin
					if (owned(cur_q, stat.owner, h_q)) begin
						rover_q <= cur_q;
						state_q <= S_TOT_INIT;
					end else if ((((rd_nxt == NIL) ? '0 : rd_nxt) == fstart_q) ||
						steps_q == STEP_W'(NUM_DESC + 1)) begin
						st_q    <= ST_NOTFOUND;
						state_q <= S_TOT_INIT;
					end else begin
						steps_q <= steps_q + STEP_W'(1);
						cur_q   <= (rd_nxt == NIL) ? '0 : rd_nxt;
						state_q <= S_FD_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_done_with_status: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (res_q.strobe && res_q.last))
		else $error("item finished without a status beat");

	a_notice_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(res_q.strobe && !res_q.last) |-> busy)
		else $error("notice beat outside an item");

	a_rover_range: assert property (@(posedge clk) disable iff (!arst_n)
		rover_q < IDX_W'(NUM_DESC))
		else $error("rover out of range");

	a_spare_range: assert property (@(posedge clk) disable iff (!arst_n)
		(spare_q < IDX_W'(NUM_DESC)) || (spare_q == NIL))
		else $error("spare list head is not an index or end mark");

endmodule

// File: design/purgeable_segment_allocator.sv
`timescale 1ns / 1ps
// A request turned away before init goes straight to its status beat; init writes
// every descriptor in turn. Other requests walk the list with one registered store
// read per step, so their duration depends on list length and passes.
// One item at a time; busy stays high until the status beat. Results cannot be
// stalled. Reset clears control state and restores the heap settings; the
// descriptor store holds nothing valid until an init request rebuilds it.
module purgeable_segment_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [2:0]                    opcode,
	input  logic [psa_pkg::HANDLE_W-1:0]  handle,
	input  logic [19:0]                   size_bytes,
	input  logic [1:0]                    purge_level,
	input  logic                          lock_flag,
	output logic                          result_strobe,
	output logic [1:0]                    kind,
	output logic [psa_pkg::HANDLE_W-1:0]  owner,
	output logic [15:0]                   new_segment,
	output logic [15:0]                   old_segment,
	output logic [15:0]                   move_paragraphs,
	output logic [1:0]                    status,
	output logic [15:0]                   unused_paragraphs,
	output logic [15:0]                   reclaimable_paragraphs,
	output logic                          last_item,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [15:0]                   cfg_data
);
	import psa_pkg::*;

	psa_cmd_t    cmd;
	psa_stat_t   stat;
	psa_result_t res;

	assign cfg_ready = 1'b1;

	psa_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.opcode      (opcode),
		.handle      (handle),
		.size_bytes  (size_bytes),
		.purge_level (purge_level),
		.lock_flag   (lock_flag),
		.busy        (busy),
		.cmd         (cmd),
		.stat        (stat),
		.res         (res)
	);

	psa_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_idx   (cfg_index),
		.cfg_wdata (cfg_data),
		.stat      (stat)
	);

	assign result_strobe          = res.strobe;
	assign kind                   = res.kind;
	assign owner                  = res.owner;
	assign new_segment            = res.new_seg;
	assign old_segment            = res.old_seg;
	assign move_paragraphs        = res.move_len;
	assign status                 = res.status;
	assign unused_paragraphs      = res.unused;
	assign reclaimable_paragraphs = res.reclaim;
	assign last_item              = res.last;

endmodule
